>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deadband cost block. They expand
// to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define VDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define VDC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define VDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define VDC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/vdc_pkg.sv
// ----------------------------------------------------------------------------
// vdc_pkg
// Types and fixed constants of the velocity deadband cost block: field
// widths, register indexes, reset values and sequencer codes.
// ----------------------------------------------------------------------------
package vdc_pkg;

   // Field widths.
   localparam int DB_W       = 16;
   localparam int COST_W     = 48;
   localparam int PEN_W      = 24;
   localparam int WEIGHT_W   = 16;
   localparam int STEP_T_W   = 16;
   localparam int POW_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Shared multiplier: 48-bit multiplicand by one 16-bit digit per pass.
   localparam int DIGIT_W    = 16;
   localparam int NUM_DIGITS = 3;
   localparam int DIG_IDX_W  = 2;
   localparam int PROD_W     = COST_W + DIGIT_W;
   localparam int ACC_W      = COST_W + NUM_DIGITS * DIGIT_W;

   // Fixed-point bookkeeping.
   localparam int Q_SHIFT    = 16;
   localparam int WRAP_W     = 64;
   localparam int SCALED_W   = PEN_W + STEP_T_W + WEIGHT_W;

   localparam logic [PEN_W-1:0]  PEN_MAX  = '1;
   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Register reset values.
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 16'd8960;
   localparam logic [POW_W-1:0]    POWER_RESET     = 4'd1;
   localparam logic [STEP_T_W-1:0] STEP_TIME_RESET = 16'd3277;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADBAND_X   = 4'd0,
      CSR_DEADBAND_Y   = 4'd1,
      CSR_DEADBAND_YAW = 4'd2,
      CSR_COST_WEIGHT  = 4'd3,
      CSR_EXPONENT     = 4'd4,
      CSR_STEP_TIME    = 4'd5,
      CSR_HOLONOMIC    = 4'd6,
      CSR_ENABLED      = 4'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_NEXT,
      ST_DONE
   } state_type;

   // Which product the shared multiplier is working on.
   typedef enum logic [1:0] {
      OP_STEP_TIME,
      OP_WEIGHT,
      OP_POWER
   } op_type;

endpackage

>>> hw/rtl/vdc_if.sv
// ----------------------------------------------------------------------------
// vdc_if
// Valid/ready channel interfaces of the deadband cost block: trajectory step
// words in, cost words out, and configuration register writes.
// ----------------------------------------------------------------------------

// Trajectory step channel.
interface vdc_req_if #(
   parameter int VEL_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   logic signed [VEL_WIDTH-1:0]     vel_x;
   logic signed [VEL_WIDTH-1:0]     vel_y;
   logic signed [VEL_WIDTH-1:0]     vel_yaw;
   logic [vdc_pkg::COST_W-1:0]      prior_cost;
   logic                            last_step;

   modport source (output valid, vel_x, vel_y, vel_yaw, prior_cost, last_step,
                   input ready);
   modport sink   (input valid, vel_x, vel_y, vel_yaw, prior_cost, last_step,
                   output ready);
endinterface

// Cost result channel.
interface vdc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vdc_pkg::COST_W-1:0]  total_cost;
   logic [vdc_pkg::COST_W-1:0]  term_cost;

   modport source (output valid, total_cost, term_cost, input ready);
   modport sink   (input valid, total_cost, term_cost, output ready);
endinterface

// Configuration write channel.
interface vdc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vdc_pkg::CSR_IDX_W-1:0]   index;
   logic [vdc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/velocity_deadband_cost_unit.sv
// ----------------------------------------------------------------------------
// velocity_deadband_cost_unit
// Deadband critic for sampled trajectories. Each step word adds, per axis (y
// only if holonomic), max(|deadband| - |velocity|, 0) to a saturating running
// sum; the final step scales the sum by step time and weight, applies the
// integer power and adds the prior cost, or passes the prior cost if disabled.
// ----------------------------------------------------------------------------
// A step word that is not the last of its trajectory leaves the block idle,
// and the next word may follow straight away. The last step word runs the sum
// through a single shared 48 x 16 bit multiplier, one 16-bit digit of the
// multiplier operand per pass (multiply state, then accumulate state), three
// passes and one decision state per product. With the block enabled there is a
// product for step time, one for weight and one more per power above 1; when
// disabled it goes straight to the output load. No step word is taken until
// the block is back in idle. A result waits in an output register, so the
// block takes new step words while it is held; a finished result is only held
// back if that register is still full. Configuration writes are taken in any
// cycle but must only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module velocity_deadband_cost_unit #(
   parameter int VEL_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   vdc_req_if.sink     req,
   vdc_rsp_if.source   rsp,
   vdc_csr_if.sink     csr
);

   // Magnitudes carry one bit more than the wider of the two signed sources.
   localparam int MAG_W  = ((VEL_WIDTH > vdc_pkg::DB_W) ? VEL_WIDTH : vdc_pkg::DB_W) + 1;
   localparam int STEP_W = MAG_W + 2;
   localparam int SUM_W  = ((STEP_W > vdc_pkg::PEN_W) ? STEP_W : vdc_pkg::PEN_W) + 1;

   // Configuration registers.
   logic signed [vdc_pkg::DB_W-1:0]     db_x_ff, db_y_ff, db_yaw_ff;
   logic [vdc_pkg::WEIGHT_W-1:0]        weight_ff;
   logic [vdc_pkg::POW_W-1:0]           power_ff;
   logic [vdc_pkg::STEP_T_W-1:0]        step_time_ff;
   logic                                holonomic_ff;
   logic                                enabled_ff;

   // Sequencer control.
   vdc_pkg::state_type                  state_ff, state_in;
   vdc_pkg::op_type                     op_ff, op_in;
   logic [vdc_pkg::DIG_IDX_W-1:0]       dig_ff, dig_in;
   logic [vdc_pkg::POW_W-1:0]           pow_left_ff, pow_left_in;
   logic [vdc_pkg::PEN_W-1:0]           penalty_ff, penalty_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic [vdc_pkg::COST_W-1:0]          opa_ff, opa_in;
   logic [vdc_pkg::COST_W-1:0]          opb_ff, opb_in;
   logic [vdc_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [vdc_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic [vdc_pkg::COST_W-1:0]          prior_ff, prior_in;
   logic [vdc_pkg::COST_W-1:0]          total_ff, total_in;
   logic [vdc_pkg::COST_W-1:0]          term_ff, term_in;

   logic                                req_take;
   logic [MAG_W-1:0]                    term_x, term_y, term_yaw;
   logic [STEP_W-1:0]                   step_pen;
   logic [SUM_W-1:0]                    pen_sum;
   logic [vdc_pkg::PEN_W-1:0]           pen_sat;
   logic [vdc_pkg::DIGIT_W-1:0]         digit;
   logic [vdc_pkg::COST_W-1:0]          weighted;
   logic [vdc_pkg::COST_W-1:0]          powered;
   logic [vdc_pkg::COST_W:0]            total_sum;

   // Magnitude of a signed velocity sample, exact for the most negative code.
   function automatic logic [MAG_W-1:0] vel_mag(input logic signed [VEL_WIDTH-1:0] v);
      logic signed [MAG_W-1:0] s;
      s = MAG_W'(v);
      return s[MAG_W-1] ? $unsigned(-s) : $unsigned(s);
   endfunction

   // Magnitude of a signed deadband register.
   function automatic logic [MAG_W-1:0] db_mag(input logic signed [vdc_pkg::DB_W-1:0] d);
      logic signed [MAG_W-1:0] s;
      s = MAG_W'(d);
      return s[MAG_W-1] ? $unsigned(-s) : $unsigned(s);
   endfunction

   // Amount by which the deadband exceeds the velocity, else zero.
   function automatic logic [MAG_W-1:0] axis_term(input logic [MAG_W-1:0] d,
                                                  input logic [MAG_W-1:0] v);
      return (d > v) ? (d - v) : '0;
   endfunction

   assign req_take  = req.valid && req.ready;
   assign req.ready = (state_ff == vdc_pkg::ST_IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.total_cost = total_ff;
   assign rsp.term_cost  = term_ff;

   // Per-step penalty and the saturating running sum.
   always_comb begin
      term_x   = axis_term(db_mag(db_x_ff), vel_mag(req.vel_x));
      term_y   = holonomic_ff ? axis_term(db_mag(db_y_ff), vel_mag(req.vel_y)) : '0;
      term_yaw = axis_term(db_mag(db_yaw_ff), vel_mag(req.vel_yaw));
      step_pen = STEP_W'(term_x) + STEP_W'(term_y) + STEP_W'(term_yaw);
      pen_sum  = SUM_W'(penalty_ff) + SUM_W'(step_pen);
      pen_sat  = (pen_sum > SUM_W'(vdc_pkg::PEN_MAX)) ? vdc_pkg::PEN_MAX
                                                        : pen_sum[vdc_pkg::PEN_W-1:0];
   end

   // Digit of the multiplier operand for the current pass, most significant first.
   always_comb begin
      case (dig_ff)
         2'd0:    digit = opb_ff[0*vdc_pkg::DIGIT_W +: vdc_pkg::DIGIT_W];
         2'd1:    digit = opb_ff[1*vdc_pkg::DIGIT_W +: vdc_pkg::DIGIT_W];
         2'd2:    digit = opb_ff[2*vdc_pkg::DIGIT_W +: vdc_pkg::DIGIT_W];
         default: digit = '0;
      endcase
   end

   // Shared multiplier and shift-accumulate.
   assign prod_in = vdc_pkg::PROD_W'(opa_ff) * vdc_pkg::PROD_W'(digit);
   assign acc_in  = (state_ff == vdc_pkg::ST_ACC)
                  ? ((acc_ff << vdc_pkg::DIGIT_W) + vdc_pkg::ACC_W'(prod_ff))
                  : ((state_ff == vdc_pkg::ST_MUL) ? acc_ff : '0);

   // Q32.16 results of the weight product and of one power step.
   assign weighted = acc_ff[vdc_pkg::COST_W+vdc_pkg::Q_SHIFT-1:vdc_pkg::Q_SHIFT];
   assign powered  = (acc_ff[vdc_pkg::ACC_W-1:vdc_pkg::WRAP_W] != '0) ? vdc_pkg::COST_MAX
                   : acc_ff[vdc_pkg::COST_W+vdc_pkg::Q_SHIFT-1:vdc_pkg::Q_SHIFT];
   assign total_sum = {1'b0, prior_ff} + {1'b0, opa_ff};

   // Sequencer: next state and datapath loads.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dig_in       = dig_ff;
      pow_left_in  = pow_left_ff;
      penalty_in   = penalty_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      prior_in     = prior_ff;
      total_in     = total_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         vdc_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req.last_step) begin
                  penalty_in = '0;
                  prior_in   = req.prior_cost;
                  if (enabled_ff) begin
                     opa_in   = vdc_pkg::COST_W'(pen_sat);
                     opb_in   = vdc_pkg::COST_W'(step_time_ff);
                     op_in    = vdc_pkg::OP_STEP_TIME;
                     dig_in   = vdc_pkg::DIG_IDX_W'(vdc_pkg::NUM_DIGITS - 1);
                     state_in = vdc_pkg::ST_MUL;
                  end else begin
                     opa_in   = '0;
                     state_in = vdc_pkg::ST_DONE;
                  end
               end else begin
                  penalty_in = pen_sat;
               end
            end
         end

         vdc_pkg::ST_MUL: begin
            state_in = vdc_pkg::ST_ACC;
         end

         vdc_pkg::ST_ACC: begin
            if (dig_ff == '0) begin
               state_in = vdc_pkg::ST_NEXT;
            end else begin
               dig_in   = dig_ff - 1'b1;
               state_in = vdc_pkg::ST_MUL;
            end
         end

         vdc_pkg::ST_NEXT: begin
            dig_in = vdc_pkg::DIG_IDX_W'(vdc_pkg::NUM_DIGITS - 1);
            case (op_ff)
               vdc_pkg::OP_STEP_TIME: begin
                  opa_in   = acc_ff[vdc_pkg::COST_W-1:0];
                  opb_in   = vdc_pkg::COST_W'(weight_ff);
                  op_in    = vdc_pkg::OP_WEIGHT;
                  state_in = vdc_pkg::ST_MUL;
               end
               vdc_pkg::OP_WEIGHT: begin
                  opa_in = weighted;
                  if (power_ff > vdc_pkg::POW_W'(1)) begin
                     opb_in      = weighted;
                     pow_left_in = power_ff - 1'b1;
                     op_in       = vdc_pkg::OP_POWER;
                     state_in    = vdc_pkg::ST_MUL;
                  end else begin
                     state_in = vdc_pkg::ST_DONE;
                  end
               end
               vdc_pkg::OP_POWER: begin
                  opa_in      = powered;
                  pow_left_in = pow_left_ff - 1'b1;
                  if (pow_left_ff == vdc_pkg::POW_W'(1)) begin
                     state_in = vdc_pkg::ST_DONE;
                  end else begin
                     state_in = vdc_pkg::ST_MUL;
                  end
               end
               default: begin
                  state_in = vdc_pkg::ST_IDLE;
               end
            endcase
         end

         vdc_pkg::ST_DONE: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp.ready) begin
               total_in     = total_sum[vdc_pkg::COST_W] ? vdc_pkg::COST_MAX
                                                         : total_sum[vdc_pkg::COST_W-1:0];
               term_in      = opa_ff;
               rsp_valid_in = 1'b1;
               state_in     = vdc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vdc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vdc_pkg::ST_IDLE;
         op_ff        <= vdc_pkg::OP_STEP_TIME;
         dig_ff       <= '0;
         pow_left_ff  <= '0;
         penalty_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         dig_ff       <= dig_in;
         pow_left_ff  <= pow_left_in;
         penalty_ff   <= penalty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      prior_ff <= prior_in;
      total_ff <= total_in;
      term_ff  <= term_in;
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         db_x_ff      <= '0;
         db_y_ff      <= '0;
         db_yaw_ff    <= '0;
         weight_ff    <= vdc_pkg::WEIGHT_RESET;
         power_ff     <= vdc_pkg::POWER_RESET;
         step_time_ff <= vdc_pkg::STEP_TIME_RESET;
         holonomic_ff <= 1'b0;
         enabled_ff   <= 1'b1;
      end else if (csr.valid && csr.ready) begin
         case (vdc_pkg::csr_index_type'(csr.index))
            vdc_pkg::CSR_DEADBAND_X:   db_x_ff      <= $signed(csr.data);
            vdc_pkg::CSR_DEADBAND_Y:   db_y_ff      <= $signed(csr.data);
            vdc_pkg::CSR_DEADBAND_YAW: db_yaw_ff    <= $signed(csr.data);
            vdc_pkg::CSR_COST_WEIGHT:  weight_ff    <= csr.data;
            vdc_pkg::CSR_EXPONENT:     power_ff     <= csr.data[vdc_pkg::POW_W-1:0];
            vdc_pkg::CSR_STEP_TIME:    step_time_ff <= csr.data;
            vdc_pkg::CSR_HOLONOMIC:    holonomic_ff <= csr.data[0];
            vdc_pkg::CSR_ENABLED:      enabled_ff   <= csr.data[0];
            default: ;
         endcase
      end
   end

   // A step word that is not the last leaves the block ready for the next.
   `VDC_ASSERT_NXT(a_mid_step_stays_idle, clock, reset, req_take && !req.last_step, state_ff == vdc_pkg::ST_IDLE)
   // The running sum is cleared by every last step word.
   `VDC_ASSERT_NXT(a_sum_cleared_on_last, clock, reset, req_take && req.last_step, penalty_ff == '0)
   // The scaled sum always fits in 56 bits before the Q16 shift.
   `VDC_ASSERT_IMP(a_weight_product_fits, clock, reset, (state_ff == vdc_pkg::ST_NEXT) && (op_ff == vdc_pkg::OP_WEIGHT), acc_ff[vdc_pkg::ACC_W-1:vdc_pkg::SCALED_W] == '0)
   // A power step is only finished while at least one remains.
   `VDC_ASSERT_IMP(a_power_count_live, clock, reset, (state_ff == vdc_pkg::ST_NEXT) && (op_ff == vdc_pkg::OP_POWER), pow_left_ff != '0)

endmodule

>>> bench/velocity_deadband_cost_unit_test.sv
// ----------------------------------------------------------------------------
// velocity_deadband_cost_unit_test
// Self-checking bench for the velocity deadband cost block. A short directed
// list of step words and register writes opens the run, then eight phases of
// randomised trajectories under random register settings follow. Every
// accepted step word goes through a bit-exact cost predictor. Every cost word
// that leaves is compared with the oldest expected one, typed or predicted.
// ----------------------------------------------------------------------------
module velocity_deadband_cost_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int IDLE_PERCENT  = 23;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 160;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_WORDS   = 85;
   localparam int STEADY_PHASE  = 0;
   localparam int PRESSURE_PHASE = 3;
   localparam int SATURATE_PHASE = 5;
   localparam int DISABLED_PHASE = 6;
   localparam int LONG_TRAJ_LEN  = 180;
   localparam int MAX_REPORTS    = 10;

   // Register indexes with no register behind them.
   localparam logic [vdc_pkg::CSR_IDX_W-1:0] CSR_SPARE_FIRST = 4'd8;
   localparam logic [vdc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LAST  = 4'd15;

   typedef struct packed {
      logic [15:0]                vel_x;
      logic [15:0]                vel_y;
      logic [15:0]                vel_yaw;
      logic [vdc_pkg::COST_W-1:0] prior_cost;
      logic                       last_step;
   } step_word_type;

   typedef struct packed {
      logic [vdc_pkg::COST_W-1:0] total_cost;
      logic [vdc_pkg::COST_W-1:0] term_cost;
   } cost_word_type;

   typedef enum logic {
      ROW_STEP,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [vdc_pkg::CSR_IDX_W-1:0]   reg_index;
      logic [vdc_pkg::CSR_DATA_W-1:0]  reg_data;
      step_word_type                   word;
      bit                              typed;
      cost_word_type                   typed_cost;
   } stim_row_type;

   logic clock;
   logic reset;

   vdc_req_if #(.VEL_WIDTH(16)) step_bus ();
   vdc_rsp_if                   cost_bus ();
   vdc_csr_if                   csr_bus  ();

   velocity_deadband_cost_unit #(.VEL_WIDTH(16)) dut (
      .clock (clock),
      .reset (reset),
      .req   (step_bus),
      .rsp   (cost_bus),
      .csr   (csr_bus)
   );

   // Predictor state and its copy of the registers.
   logic [vdc_pkg::PEN_W-1:0]    penalty_sum;
   logic [vdc_pkg::DB_W-1:0]     db_x, db_y, db_yaw;
   logic [vdc_pkg::WEIGHT_W-1:0] cfg_weight;
   logic [vdc_pkg::POW_W-1:0]    cfg_power;
   logic [vdc_pkg::STEP_T_W-1:0] cfg_step_time;
   logic                         cfg_holonomic;
   logic                         cfg_enabled;

   cost_word_type       expected_costs[$];
   stim_row_type        directed_rows[$];
   int unsigned         fail_count;
   int unsigned         cycle_count;

   // Typed expectation travelling alongside the step word on the bus.
   bit                  typed_valid;
   cost_word_type       typed_cost;

   bit                  steady_phase;
   bit                  pressure_phase;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Magnitude of a signed Q8.8 value; the most negative one gives 32768.
   function automatic logic [16:0] vel_magnitude(input logic [15:0] v);
      return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   function automatic logic [16:0] axis_shortfall(input logic [15:0] db, input logic [15:0] v);
      logic [16:0] d;
      logic [16:0] m;
      d = vel_magnitude(db);
      m = vel_magnitude(v);
      return (d > m) ? d - m : 17'd0;
   endfunction

   function automatic void reset_predictor();
      penalty_sum   = '0;
      db_x          = '0;
      db_y          = '0;
      db_yaw        = '0;
      cfg_weight    = vdc_pkg::WEIGHT_RESET;
      cfg_power     = vdc_pkg::POWER_RESET;
      cfg_step_time = vdc_pkg::STEP_TIME_RESET;
      cfg_holonomic = 1'b0;
      cfg_enabled   = 1'b1;
   endfunction

   function automatic void apply_register_write(input logic [vdc_pkg::CSR_IDX_W-1:0] idx,
                                                input logic [vdc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         vdc_pkg::CSR_DEADBAND_X:   db_x          = data;
         vdc_pkg::CSR_DEADBAND_Y:   db_y          = data;
         vdc_pkg::CSR_DEADBAND_YAW: db_yaw        = data;
         vdc_pkg::CSR_COST_WEIGHT:  cfg_weight    = data;
         vdc_pkg::CSR_EXPONENT:     cfg_power     = data[vdc_pkg::POW_W-1:0];
         vdc_pkg::CSR_STEP_TIME:    cfg_step_time = data;
         vdc_pkg::CSR_HOLONOMIC:    cfg_holonomic = data[0];
         vdc_pkg::CSR_ENABLED:      cfg_enabled   = data[0];
         default: ;
      endcase
   endfunction

   // Accumulates one step and, on the last one, works out the cost word.
   function automatic bit predict_cost(input step_word_type w, output cost_word_type c);
      logic [17:0]  step_pen;
      logic [24:0]  sum;
      logic [63:0]  scaled;
      logic [63:0]  term;
      logic [63:0]  base;
      logic [127:0] prod;
      logic [48:0]  total;
      int           p;
      step_pen = 18'(axis_shortfall(db_x, w.vel_x)) + 18'(axis_shortfall(db_yaw, w.vel_yaw));
      if (cfg_holonomic)
         step_pen = step_pen + 18'(axis_shortfall(db_y, w.vel_y));
      sum = 25'(penalty_sum) + 25'(step_pen);
      penalty_sum = (sum > 25'(vdc_pkg::PEN_MAX)) ? vdc_pkg::PEN_MAX
                                                  : sum[vdc_pkg::PEN_W-1:0];
      c = '0;
      if (!w.last_step)
         return 1'b0;
      term = '0;
      if (cfg_enabled) begin
         scaled = 64'(penalty_sum) * 64'(cfg_step_time) * 64'(cfg_weight);
         term = scaled >> vdc_pkg::Q_SHIFT;
         base = term;
         // Each power product is truncated to Q32.16 and saturates on overflow.
         for (p = 1; p < int'(cfg_power); p++) begin
            prod = 128'(term) * 128'(base);
            term = (prod[127:64] != '0) ? 64'(vdc_pkg::COST_MAX) : 64'(prod[63:16]);
         end
      end
      penalty_sum = '0;
      total = 49'(w.prior_cost) + 49'(term[vdc_pkg::COST_W-1:0]);
      c.total_cost = total[vdc_pkg::COST_W] ? vdc_pkg::COST_MAX : total[vdc_pkg::COST_W-1:0];
      c.term_cost  = term[vdc_pkg::COST_W-1:0];
      return 1'b1;
   endfunction

   task automatic note_failure(input string what, input cost_word_type exp,
                               input cost_word_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s: total exp %h got %h, term exp %h got %h", what,
                  exp.total_cost, got.total_cost, exp.term_cost, got.term_cost);
   endtask

   // Bus monitor: register writes, accepted step words and cost words.
   always @(posedge clock) begin : bus_monitor
      step_word_type w;
      cost_word_type pred;
      cost_word_type got;
      cost_word_type exp;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            apply_register_write(csr_bus.index, csr_bus.data);
         if (step_bus.valid && step_bus.ready) begin
            w.vel_x      = step_bus.vel_x;
            w.vel_y      = step_bus.vel_y;
            w.vel_yaw    = step_bus.vel_yaw;
            w.prior_cost = step_bus.prior_cost;
            w.last_step  = step_bus.last_step;
            if (predict_cost(w, pred))
               expected_costs.push_back(typed_valid ? typed_cost : pred);
         end
         if (cost_bus.valid && cost_bus.ready) begin
            got.total_cost = cost_bus.total_cost;
            got.term_cost  = cost_bus.term_cost;
            if (expected_costs.size() == 0) begin
               note_failure("cost word with none expected", '0, got);
            end else begin
               exp = expected_costs.pop_front();
               if (exp.total_cost !== got.total_cost || exp.term_cost !== got.term_cost)
                  note_failure("cost word mismatch", exp, got);
            end
         end
      end
   end

   // Receiver: random back-pressure, one long hold-off in the pressure phase.
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      cost_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_phase && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            cost_bus.ready <= 1'b0;
         end else begin
            cost_bus.ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic offer_step(input step_word_type w, input bit typed,
                             input cost_word_type tc);
      while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         step_bus.valid <= 1'b0;
      end
      @(negedge clock);
      step_bus.valid      <= 1'b1;
      step_bus.vel_x      <= w.vel_x;
      step_bus.vel_y      <= w.vel_y;
      step_bus.vel_yaw    <= w.vel_yaw;
      step_bus.prior_cost <= w.prior_cost;
      step_bus.last_step  <= w.last_step;
      typed_valid         <= typed;
      typed_cost          <= tc;
      do @(posedge clock); while (!step_bus.ready);
   endtask

   task automatic write_register(input logic [vdc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [vdc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Stops offering words, waits for every expected cost word and lets the
   // block finish any product still in flight.
   task automatic settle_block();
      @(negedge clock);
      step_bus.valid <= 1'b0;
      while (expected_costs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic stim_row_type step_row(input logic [15:0] vx, input logic [15:0] vy,
                                             input logic [15:0] vyaw,
                                             input logic [vdc_pkg::COST_W-1:0] prior,
                                             input logic last, input bit typed,
                                             input logic [vdc_pkg::COST_W-1:0] total,
                                             input logic [vdc_pkg::COST_W-1:0] term);
      stim_row_type r;
      r.kind                  = ROW_STEP;
      r.reg_index             = '0;
      r.reg_data              = '0;
      r.word.vel_x            = vx;
      r.word.vel_y            = vy;
      r.word.vel_yaw          = vyaw;
      r.word.prior_cost       = prior;
      r.word.last_step        = last;
      r.typed                 = typed;
      r.typed_cost.total_cost = total;
      r.typed_cost.term_cost  = term;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [vdc_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [vdc_pkg::CSR_DATA_W-1:0] data);
      stim_row_type r;
      r            = step_row('0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
      r.kind       = ROW_CSR;
      r.reg_index  = idx;
      r.reg_data   = data;
      return r;
   endfunction

   function automatic logic [vdc_pkg::COST_W-1:0] pick_prior();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       return '0;
         1:       return vdc_pkg::COST_MAX;
         2:       return vdc_pkg::COST_MAX - vdc_pkg::COST_W'(r[15:0]);
         default: return r[vdc_pkg::COST_W-1:0];
      endcase
   endfunction

   // Velocity sample: full range, extremes, or close to the axis deadband.
   function automatic logic [15:0] pick_velocity(input logic [15:0] db);
      int          mag;
      logic [15:0] v;
      case ($urandom_range(4))
         0: v = 16'($urandom);
         1: v = '0;
         2: begin
            case ($urandom_range(3))
               0:       v = 16'h8000;
               1:       v = 16'h7FFF;
               2:       v = 16'h8001;
               default: v = 16'hFFFF;
            endcase
         end
         default: begin
            mag = int'(vel_magnitude(db)) + int'($urandom_range(0, 1023)) - 512;
            if (mag < 0)
               mag = 0;
            if (mag > 32767)
               mag = 32767;
            v = 16'(mag);
            if ($urandom_range(1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_wide_setting();
      case ($urandom_range(4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_deadband();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [vdc_pkg::POW_W-1:0] pick_power();
      case ($urandom_range(3))
         0:       return vdc_pkg::POW_W'($urandom_range(0, 1));
         1:       return vdc_pkg::POW_W'(2);
         2:       return vdc_pkg::POW_W'($urandom_range(3, 8));
         default: return vdc_pkg::POW_W'($urandom_range(9, 15));
      endcase
   endfunction

   // Writes every register once, with random upper bits to check masking.
   task automatic program_random_settings(input int phase);
      logic [15:0] noise;
      logic        en;
      noise = 16'($urandom);
      en    = (phase == DISABLED_PHASE) ? 1'b0 : ($urandom_range(3) != 0);
      if (phase == SATURATE_PHASE) begin
         write_register(vdc_pkg::CSR_DEADBAND_X,   16'h8000);
         write_register(vdc_pkg::CSR_DEADBAND_Y,   16'h8000);
         write_register(vdc_pkg::CSR_DEADBAND_YAW, 16'h8000);
         write_register(vdc_pkg::CSR_HOLONOMIC,    {noise[15:1], 1'b1});
      end else begin
         write_register(vdc_pkg::CSR_DEADBAND_X,   pick_deadband());
         write_register(vdc_pkg::CSR_DEADBAND_Y,   pick_deadband());
         write_register(vdc_pkg::CSR_DEADBAND_YAW, pick_deadband());
         write_register(vdc_pkg::CSR_HOLONOMIC,    16'($urandom));
      end
      write_register(vdc_pkg::CSR_COST_WEIGHT, pick_wide_setting());
      write_register(vdc_pkg::CSR_EXPONENT,    {noise[15:vdc_pkg::POW_W], pick_power()});
      write_register(vdc_pkg::CSR_STEP_TIME,   pick_wide_setting());
      write_register(vdc_pkg::CSR_ENABLED,     {noise[14:0], en});
      write_register(vdc_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                     16'($urandom));
   endtask

   function automatic int pick_length(input int phase);
      if (phase == PRESSURE_PHASE)
         return $urandom_range(1, 2);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(1, 4);
         5, 6, 7:       return $urandom_range(5, 16);
         8:             return $urandom_range(17, 64);
         default:       return $urandom_range(65, 80);
      endcase
   endfunction

   // Main sequence.
   initial begin
      step_word_type w;
      bit         steps_pending;
      int         words;
      int         traj_len;
      int         k;
      int         phase;

      reset          = 1'b1;
      step_bus.valid      = 1'b0;
      step_bus.vel_x      = '0;
      step_bus.vel_y      = '0;
      step_bus.vel_yaw    = '0;
      step_bus.prior_cost = '0;
      step_bus.last_step  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      typed_valid    = 1'b0;
      typed_cost     = '0;
      steady_phase   = 1'b0;
      pressure_phase = 1'b0;
      steps_pending  = 1'b0;
      reset_predictor();

      // Directed list: reset settings, the extremes and the special cases.
      directed_rows.push_back(step_row(16'h7FFF, 16'h8000, 16'h0000, '0, 1'b0,
                                       1'b0, '0, '0));
      directed_rows.push_back(step_row(16'h0001, 16'hFFFF, 16'h8001, 48'd123456, 1'b1,
                                       1'b1, 48'd123456, '0));
      directed_rows.push_back(step_row(16'h8000, 16'h8000, 16'h8000, vdc_pkg::COST_MAX,
                                       1'b1, 1'b1, vdc_pkg::COST_MAX, '0));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_DEADBAND_X,   16'h8000));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_DEADBAND_Y,   16'h7FFF));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_DEADBAND_YAW, 16'h8000));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_HOLONOMIC,    16'h0001));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_STEP_TIME,    16'hFFFF));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_COST_WEIGHT,  16'hFFFF));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_EXPONENT,     16'h000F));
      // Full deadband on every axis raised to the highest power saturates.
      directed_rows.push_back(step_row('0, '0, '0, '0, 1'b1, 1'b1,
                                       vdc_pkg::COST_MAX, vdc_pkg::COST_MAX));
      directed_rows.push_back(step_row(16'h8000, 16'h8001, 16'h7FFF, 48'd5, 1'b1,
                                       1'b0, '0, '0));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_EXPONENT,     16'h0000));
      directed_rows.push_back(step_row(16'h0100, 16'hFF00, 16'h0000, vdc_pkg::COST_MAX,
                                       1'b0, 1'b0, '0, '0));
      directed_rows.push_back(step_row(16'h7FFF, 16'h0000, 16'hFFFF,
                                       vdc_pkg::COST_MAX - 48'd1, 1'b1, 1'b0, '0, '0));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_ENABLED,      16'hFFFE));
      // Disabled: the prior cost passes through untouched.
      directed_rows.push_back(step_row('0, '0, '0, 48'd777, 1'b1, 1'b1, 48'd777, '0));
      directed_rows.push_back(csr_row(CSR_SPARE_FIRST + 4'd1,    16'hFFFF));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_ENABLED,      16'h0003));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_EXPONENT,     16'hFFF8));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_HOLONOMIC,    16'h0000));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_STEP_TIME,    16'h0001));
      directed_rows.push_back(csr_row(vdc_pkg::CSR_COST_WEIGHT,  16'h0100));
      directed_rows.push_back(step_row(16'h8000, 16'h0000, 16'h0000, '0, 1'b0,
                                       1'b0, '0, '0));
      directed_rows.push_back(step_row(16'hFFFF, 16'h7FFF, 16'h0001, 48'h0000_8000_0000,
                                       1'b1, 1'b0, '0, '0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (steps_pending) begin
               settle_block();
               steps_pending = 1'b0;
            end
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            offer_step(directed_rows[i].word, directed_rows[i].typed,
                       directed_rows[i].typed_cost);
            steps_pending = 1'b1;
         end
      end
      settle_block();

      // Random phases of whole trajectories with random content.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         program_random_settings(phase);
         steady_phase   = (phase == STEADY_PHASE);
         pressure_phase = (phase == PRESSURE_PHASE);
         words = 0;
         while (words < PHASE_WORDS) begin
            traj_len = (phase == SATURATE_PHASE && words == 0) ? LONG_TRAJ_LEN
                                                               : pick_length(phase);
            for (k = 0; k < traj_len; k++) begin
               if (phase == SATURATE_PHASE && words < LONG_TRAJ_LEN) begin
                  // Small velocities so the running sum reaches its ceiling.
                  w.vel_x   = $urandom_range(1) ? -16'($urandom_range(0, 255))
                                                : 16'($urandom_range(0, 255));
                  w.vel_y   = 16'($urandom_range(0, 255));
                  w.vel_yaw = -16'($urandom_range(0, 255));
               end else begin
                  w.vel_x   = pick_velocity(db_x);
                  w.vel_y   = pick_velocity(db_y);
                  w.vel_yaw = pick_velocity(db_yaw);
               end
               w.prior_cost = pick_prior();
               w.last_step  = (k == traj_len - 1);
               offer_step(w, 1'b0, '0);
               words++;
            end
         end
         settle_block();
         steady_phase   = 1'b0;
         pressure_phase = 1'b0;
      end

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
